/* rtl/core/erm_pkg.sv */
// Shared types and constants for the event rate monitor.
`timescale 1ns / 1ps

package erm_pkg;

    localparam int MAX_SEQ   = 4;
    localparam int MAX_WATCH = 4;
    localparam int ID_W      = 9;
    localparam int LIMIT_W   = 16;
    localparam int POS_W     = 3;
    localparam int LEN_W     = 3;
    localparam int SEQ_IDS_W = MAX_SEQ * ID_W;
    localparam int WATCH_IDS_W = MAX_WATCH * ID_W;
    localparam int LIMITS_W  = MAX_WATCH * LIMIT_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam int WARN_W    = 4;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_TRIG_SEQ_IDS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRIG_SEQ_LEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WATCH_IDS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WATCH_LIMITS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WATCH_COUNT  = 3'd4;

    // request kinds
    localparam logic REQ_EVENT = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    typedef struct packed {
        logic armed_now;   // armed after this item
        logic fired;       // this item completed the trigger sequence
    } erm_trig_status_t;

endpackage

/* rtl/core/erm_trig.sv */
// Trigger sequence matcher: match position and armed flag.
`timescale 1ns / 1ps

module erm_trig (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            step_en,
    input  logic                            is_event,
    input  logic [erm_pkg::ID_W-1:0]        call_id,
    input  logic [erm_pkg::SEQ_IDS_W-1:0]   seq_ids,
    input  logic [erm_pkg::LEN_W-1:0]       seq_len,
    output erm_pkg::erm_trig_status_t       status
);
    import erm_pkg::*;

    logic [POS_W-1:0] match_pos_reg;
    logic [POS_W-1:0] match_pos_next;
    logic             armed_reg;
    logic             armed_next;
    logic [LEN_W-1:0] len_eff;
    logic [POS_W-1:0] pos_start;
    logic [POS_W-1:0] pos_adv;
    logic [ID_W-1:0]  seq_id_at_pos;
    logic             fire;

    always_comb begin
        if (seq_len == '0) begin
            len_eff = LEN_W'(1);
        end else if (seq_len > LEN_W'(MAX_SEQ)) begin
            len_eff = LEN_W'(MAX_SEQ);
        end else begin
            len_eff = seq_len;
        end

        // length may have shrunk mid-match
        pos_start = (match_pos_reg >= POS_W'(len_eff)) ? '0 : match_pos_reg;
        seq_id_at_pos = seq_ids[pos_start[1:0]*ID_W +: ID_W];

        if (seq_id_at_pos == call_id) begin
            pos_adv = pos_start + POS_W'(1);
        end else if (seq_ids[ID_W-1:0] == call_id) begin
            pos_adv = POS_W'(1);
        end else begin
            pos_adv = '0;
        end

        fire = is_event && !armed_reg && (pos_adv == POS_W'(len_eff));

        match_pos_next = match_pos_reg;
        armed_next     = armed_reg;
        if (is_event && !armed_reg) begin
            match_pos_next = fire ? '0 : pos_adv;
            armed_next     = fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_pos_reg <= '0;
            armed_reg     <= 1'b0;
        end else if (step_en) begin
            match_pos_reg <= match_pos_next;
            armed_reg     <= armed_next;
        end
    end

    assign status.armed_now = armed_reg | fire;
    assign status.fired     = fire;

endmodule

/* rtl/core/erm_watch.sv */
// Per-slot call counters with limit check and saturation.
`timescale 1ns / 1ps

module erm_watch (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             step_en,
    input  logic                             is_tick,
    input  logic                             armed_now,
    input  logic [erm_pkg::ID_W-1:0]         call_id,
    input  logic [erm_pkg::WATCH_IDS_W-1:0]  watch_ids,
    input  logic [erm_pkg::LIMITS_W-1:0]     watch_limits,
    input  logic [erm_pkg::LEN_W-1:0]        watch_count,
    output logic [erm_pkg::WARN_W-1:0]       warn_mask
);
    import erm_pkg::*;

    logic [LIMIT_W-1:0] count_reg  [MAX_WATCH];
    logic [LIMIT_W-1:0] count_next [MAX_WATCH];
    logic [LIMIT_W-1:0] count_inc  [MAX_WATCH];
    logic [LEN_W-1:0]   n_eff;
    logic [MAX_WATCH-1:0] warn_all;

    always_comb begin
        n_eff = (watch_count > LEN_W'(MAX_WATCH)) ? LEN_W'(MAX_WATCH) : watch_count;
        for (int i = 0; i < MAX_WATCH; i++) begin
            count_inc[i] = count_reg[i];
            warn_all[i]  = 1'b0;
            if ((LEN_W'(i) < n_eff) && (watch_ids[i*ID_W +: ID_W] == call_id)
                    && (count_reg[i] != '1)) begin
                count_inc[i] = count_reg[i] + LIMIT_W'(1);
            end
            if ((LEN_W'(i) < n_eff)
                    && (count_inc[i] >= watch_limits[i*LIMIT_W +: LIMIT_W])) begin
                warn_all[i] = !is_tick && armed_now;
            end

            if (is_tick) begin
                count_next[i] = '0;
            end else if (armed_now) begin
                count_next[i] = warn_all[i] ? '0 : count_inc[i];
            end else begin
                count_next[i] = count_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_WATCH; i++) begin
                count_reg[i] <= '0;
            end
        end else if (step_en) begin
            for (int i = 0; i < MAX_WATCH; i++) begin
                count_reg[i] <= count_next[i];
            end
        end
    end

    assign warn_mask = warn_all[WARN_W-1:0];

endmodule

/* rtl/core/event_rate_monitor_with_trigger.sv */
// Top level of the event rate monitor with trigger sequence.
`timescale 1ns / 1ps

// Takes one item per clock while m_tready is high or the result register is empty:
// a call event (id in tdata) or a one-second tick (tuser set). Until the configured
// trigger sequence of ids has been seen the block only tracks the sequence; from
// the completing event on it counts calls per watch slot and flags slots reaching
// their limit. Each item gives one result. Sustained rate is one item per cycle
// while m_tready is high; an item passes the input register and then the result
// register, with all per-item work done in one combinational pass between them.
// Configuration writes belong to idle periods.
module event_rate_monitor_with_trigger (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration
    input  logic                               cfg_wr_en,
    input  logic [erm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [erm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // input items
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [15:0]                        s_tdata,   // [8:0] call_id
    input  logic                               s_tuser,   // [0] req_type
    // result items
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [7:0]                         m_tdata    // [0] armed, [1] trigger_fired,
                                                          // [5:2] warn_mask
);
    import erm_pkg::*;

    logic [SEQ_IDS_W-1:0]   trig_ids_reg;
    logic [LEN_W-1:0]       trig_len_reg;
    logic [WATCH_IDS_W-1:0] watch_ids_reg;
    logic [LIMITS_W-1:0]    watch_limits_reg;
    logic [LEN_W-1:0]       watch_count_reg;

    logic                   in_valid_reg;
    logic                   in_type_reg;
    logic [ID_W-1:0]        in_id_reg;
    logic                   out_valid_reg;
    logic [7:0]             out_data_reg;
    logic [7:0]             out_data_next;

    logic                   advance;
    logic                   is_event;
    erm_trig_status_t       trig_status;
    logic [WARN_W-1:0]      warn_mask;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trig_ids_reg     <= '0;
            trig_len_reg     <= LEN_W'(1);
            watch_ids_reg    <= '0;
            watch_limits_reg <= '0;
            watch_count_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_TRIG_SEQ_IDS: trig_ids_reg     <= cfg_wdata[SEQ_IDS_W-1:0];
                REG_TRIG_SEQ_LEN: trig_len_reg     <= cfg_wdata[LEN_W-1:0];
                REG_WATCH_IDS:    watch_ids_reg    <= cfg_wdata[WATCH_IDS_W-1:0];
                REG_WATCH_LIMITS: watch_limits_reg <= cfg_wdata[LIMITS_W-1:0];
                REG_WATCH_COUNT:  watch_count_reg  <= cfg_wdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign is_event = (in_type_reg == REQ_EVENT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_type_reg <= s_tuser;
            in_id_reg   <= s_tdata[ID_W-1:0];
        end
    end

    erm_trig u_trig (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (advance),
        .is_event (is_event),
        .call_id  (in_id_reg),
        .seq_ids  (trig_ids_reg),
        .seq_len  (trig_len_reg),
        .status   (trig_status)
    );

    erm_watch u_watch (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (advance),
        .is_tick      (!is_event),
        .armed_now    (trig_status.armed_now),
        .call_id      (in_id_reg),
        .watch_ids    (watch_ids_reg),
        .watch_limits (watch_limits_reg),
        .watch_count  (watch_count_reg),
        .warn_mask    (warn_mask)
    );

    assign out_data_next = {2'b00, warn_mask, trig_status.fired, trig_status.armed_now};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
